/* sv/notch_lowpass_biquad_cascade_defines.svh */
// Assertion macros shared by the checker of the notch and lowpass biquad cascade.
`ifndef NOTCH_LOWPASS_BIQUAD_CASCADE_DEFINES_SVH
`define NOTCH_LOWPASS_BIQUAD_CASCADE_DEFINES_SVH

// The consequent must hold on the next clock edge; not checked while reset is high.
`define NLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold on the same clock edge; not checked while reset is high.
`define NLBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checked at every edge, reset included, for properties about reset itself.
`define NLBC_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/nlbc_pkg.sv */
// Types, sizes and codes shared by the notch and lowpass biquad cascade.
package nlbc_pkg;

   // Frame and number formats.
   localparam int CHANNELS       = 4;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
   localparam int CHAN_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // A product, and the accumulator that holds up to six of them with headroom.
   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 4;

   // Coefficient register indexes on the write port.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NOTCH_GAIN     = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_NOTCH_FB_ONE   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_NOTCH_FB_TWO   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWPASS_GAIN   = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWPASS_FB_ONE = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWPASS_FB_TWO = CSR_INDEX_BITS'(5);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;

   // The full coefficient set as held in the register bank.
   typedef struct packed {
      coef_type notch_gain;
      coef_type notch_fb_one;
      coef_type notch_fb_two;
      coef_type lowpass_gain;
      coef_type lowpass_fb_one;
      coef_type lowpass_fb_two;
   } coef_set_type;

   // Operations of the shared multiply-accumulate unit.
   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      coef_type   coef;
      sample_type data;
   } mac_cmd_type;

   // A finished frame handed from the sequencer to the output register.
   typedef struct packed {
      logic                        valid;
      sample_type [CHANNELS-1:0]   frame;
   } frame_done_type;

endpackage

/* sv/nlbc_if.sv */
// Valid/ready channel interfaces for the sample frames and the filtered frames.
interface nlbc_req_if;
   logic                 valid;
   logic                 ready;
   nlbc_pkg::sample_type sample_ch0;
   nlbc_pkg::sample_type sample_ch1;
   nlbc_pkg::sample_type sample_ch2;
   nlbc_pkg::sample_type sample_ch3;

   modport source (
      output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
      input  ready
   );
   modport sink (
      input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
      output ready
   );
endinterface

interface nlbc_rsp_if;
   logic                 valid;
   logic                 ready;
   nlbc_pkg::sample_type filtered_ch0;
   nlbc_pkg::sample_type filtered_ch1;
   nlbc_pkg::sample_type filtered_ch2;
   nlbc_pkg::sample_type filtered_ch3;

   modport source (
      output valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
      input  ready
   );
   modport sink (
      input  valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
      output ready
   );
endinterface

/* sv/nlbc_csr.sv */
// Coefficient register bank written through the plain write port.
module nlbc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [nlbc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  nlbc_pkg::coef_type                   csr_wr_data,
   output nlbc_pkg::coef_set_type               coefs
);
   import nlbc_pkg::*;

   coef_set_type coefs_ff;
   coef_set_type coefs_in;

   // Decode the index; writes beyond the last register are dropped.
   always_comb begin
      coefs_in = coefs_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_NOTCH_GAIN:     coefs_in.notch_gain     = csr_wr_data;
            REG_NOTCH_FB_ONE:   coefs_in.notch_fb_one   = csr_wr_data;
            REG_NOTCH_FB_TWO:   coefs_in.notch_fb_two   = csr_wr_data;
            REG_LOWPASS_GAIN:   coefs_in.lowpass_gain   = csr_wr_data;
            REG_LOWPASS_FB_ONE: coefs_in.lowpass_fb_one = csr_wr_data;
            REG_LOWPASS_FB_TWO: coefs_in.lowpass_fb_two = csr_wr_data;
            default: ;
         endcase
      end
   end

   // All coefficients come out of reset as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

/* sv/nlbc_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation of its sum.
module nlbc_mac (
   input  logic                  clock,
   input  nlbc_pkg::mac_cmd_type cmd,
   output nlbc_pkg::sample_type  result
);
   import nlbc_pkg::*;

   localparam int Q_BITS = ACC_BITS - COEF_FRAC_BITS;
   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
      ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [PROD_BITS-1:0] product;
   logic signed [ACC_BITS-1:0]  product_ext;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [ACC_BITS-1:0]  rounded;
   logic signed [Q_BITS-1:0]    quotient;
   logic                        in_range;

   // One signed product per cycle, loaded, added or subtracted, unless the command holds the sum.
   always_comb begin
      product     = cmd.coef * cmd.data;
      product_ext = ACC_BITS'(product);
      case (cmd.op)
         MAC_LOAD: acc_in = product_ext;
         MAC_ADD:  acc_in = acc_ff + product_ext;
         MAC_SUB:  acc_in = acc_ff - product_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round half up, drop the fraction, and clamp to the sample range.
   always_comb begin
      rounded  = acc_ff + ROUND_BIAS;
      quotient = rounded[ACC_BITS-1:COEF_FRAC_BITS];
      in_range = (quotient[Q_BITS-1:SAMPLE_BITS-1] ==
                  {(Q_BITS-SAMPLE_BITS+1){quotient[SAMPLE_BITS-1]}});
      if (in_range) begin
         result = quotient[SAMPLE_BITS-1:0];
      end else if (quotient[Q_BITS-1]) begin
         result = SAT_LO;
      end else begin
         result = SAT_HI;
      end
   end

endmodule

/* sv/nlbc_seq.sv */
// Sequencer that steps each channel through the notch and lowpass taps on the shared unit.
module nlbc_seq (
   input  logic                     clock,
   input  logic                     reset,
   nlbc_req_if.sink                 req_chan,
   input  nlbc_pkg::coef_set_type   coefs,
   output nlbc_pkg::mac_cmd_type    mac_cmd,
   input  nlbc_pkg::sample_type     mac_result,
   input  logic                     out_busy,
   output nlbc_pkg::frame_done_type done
);
   import nlbc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   // Per-channel history. The lowpass input history is the notch output history.
   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type n1;
      sample_type n2;
      sample_type y1;
      sample_type y2;
   } hist_type;

   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_N_B0  = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_N_B1  = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_N_B2  = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_N_A1  = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_N_A2  = STEP_BITS'(4);
   localparam logic [STEP_BITS-1:0] STEP_N_FIN = STEP_BITS'(5);
   localparam logic [STEP_BITS-1:0] STEP_L_B0  = STEP_BITS'(6);
   localparam logic [STEP_BITS-1:0] STEP_L_B1A = STEP_BITS'(7);
   localparam logic [STEP_BITS-1:0] STEP_L_B1B = STEP_BITS'(8);
   localparam logic [STEP_BITS-1:0] STEP_L_B2  = STEP_BITS'(9);
   localparam logic [STEP_BITS-1:0] STEP_L_A1  = STEP_BITS'(10);
   localparam logic [STEP_BITS-1:0] STEP_L_A2  = STEP_BITS'(11);
   localparam logic [STEP_BITS-1:0] STEP_L_FIN = STEP_BITS'(12);

   seq_state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [CHAN_BITS-1:0]      chan_ff, chan_in;
   sample_type [CHANNELS-1:0] frame_ff, frame_in;
   hist_type [CHANNELS-1:0]   hist_ff, hist_in;
   sample_type                notch_ff, notch_in;
   hist_type                  cur;
   hist_type                  upd;
   sample_type                x;
   logic                      last_chan;
   logic                      stall;

   // The current channel always sits at position zero of the rotating stores.
   assign cur       = hist_ff[0];
   assign x         = frame_ff[0];
   assign last_chan = (chan_ff == CHAN_BITS'(CHANNELS - 1));
   assign stall     = (step_ff == STEP_L_FIN) && last_chan && out_busy;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Operand selection for each tap of the two biquads.
   always_comb begin
      mac_cmd.op   = MAC_HOLD;
      mac_cmd.coef = coefs.notch_gain;
      mac_cmd.data = x;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            STEP_N_B0: begin
               mac_cmd.op   = MAC_LOAD;
               mac_cmd.coef = coefs.notch_gain;
               mac_cmd.data = x;
            end
            STEP_N_B1: begin
               mac_cmd.op   = MAC_ADD;
               mac_cmd.coef = coefs.notch_fb_one;
               mac_cmd.data = cur.x1;
            end
            STEP_N_B2: begin
               mac_cmd.op   = MAC_ADD;
               mac_cmd.coef = coefs.notch_gain;
               mac_cmd.data = cur.x2;
            end
            STEP_N_A1: begin
               mac_cmd.op   = MAC_SUB;
               mac_cmd.coef = coefs.notch_fb_one;
               mac_cmd.data = cur.n1;
            end
            STEP_N_A2: begin
               mac_cmd.op   = MAC_SUB;
               mac_cmd.coef = coefs.notch_fb_two;
               mac_cmd.data = cur.n2;
            end
            STEP_L_B0: begin
               mac_cmd.op   = MAC_LOAD;
               mac_cmd.coef = coefs.lowpass_gain;
               mac_cmd.data = notch_ff;
            end
            STEP_L_B1A, STEP_L_B1B: begin
               mac_cmd.op   = MAC_ADD;
               mac_cmd.coef = coefs.lowpass_gain;
               mac_cmd.data = cur.n1;
            end
            STEP_L_B2: begin
               mac_cmd.op   = MAC_ADD;
               mac_cmd.coef = coefs.lowpass_gain;
               mac_cmd.data = cur.n2;
            end
            STEP_L_A1: begin
               mac_cmd.op   = MAC_SUB;
               mac_cmd.coef = coefs.lowpass_fb_one;
               mac_cmd.data = cur.y1;
            end
            STEP_L_A2: begin
               mac_cmd.op   = MAC_SUB;
               mac_cmd.coef = coefs.lowpass_fb_two;
               mac_cmd.data = cur.y2;
            end
            default: mac_cmd.op = MAC_HOLD;
         endcase
      end
   end

   // History entry of the current channel once both stages are finished.
   always_comb begin
      upd.x1 = x;
      upd.x2 = cur.x1;
      upd.n1 = notch_ff;
      upd.n2 = cur.n1;
      upd.y1 = mac_result;
      upd.y2 = cur.y1;
   end

   // Step, channel and frame control.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      chan_in    = chan_ff;
      frame_in   = frame_ff;
      hist_in    = hist_ff;
      notch_in   = notch_ff;
      done.valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               frame_in[0] = req_chan.sample_ch0;
               frame_in[1] = req_chan.sample_ch1;
               frame_in[2] = req_chan.sample_ch2;
               frame_in[3] = req_chan.sample_ch3;
               step_in     = STEP_N_B0;
               chan_in     = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_N_FIN) begin
               notch_in = mac_result;
            end
            if (step_ff == STEP_L_FIN) begin
               if (!stall) begin
                  // Rotate the stores so the next channel comes to position zero;
                  // the filtered sample takes the place of the raw one at the back.
                  for (int i = 0; i < CHANNELS - 1; i++) begin
                     hist_in[i]  = hist_ff[i+1];
                     frame_in[i] = frame_ff[i+1];
                  end
                  hist_in[CHANNELS-1]  = upd;
                  frame_in[CHANNELS-1] = mac_result;
                  step_in = STEP_N_B0;
                  chan_in = chan_ff + CHAN_BITS'(1);
                  if (last_chan) begin
                     done.valid = 1'b1;
                     chan_in    = '0;
                     state_in   = ST_IDLE;
                  end
               end
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase

      done.frame = frame_in;
   end

   // Control state and filter history clear on reset; frame data needs none.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_N_B0;
         chan_ff  <= '0;
         hist_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
         hist_ff  <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      notch_ff <= notch_in;
   end

endmodule

/* sv/notch_lowpass_biquad_cascade.sv */
// Top level of the four-channel notch then lowpass biquad filter cascade.
// Each accepted frame of four samples is filtered one channel at a time on a
// single 18 x 16 bit multiply-accumulate unit: each channel steps through five
// notch taps and a rounding step, then six lowpass taps and a rounding step, and
// a new frame is taken only once all four channels are done and the sequencer
// is back in idle. The filtered frame waits in an output register, so the next
// frame is accepted while it is still waiting; only when a second frame finishes
// before the first has been taken does the sequencer hold at its last step.
// Coefficients are signed Q2.16, written by index through the csr port; the user
// must write them only while no frame is in flight, which the block does not
// enforce; they all clear to zero on reset together with the filter history.
module notch_lowpass_biquad_cascade (
   input  logic                                clock,
   input  logic                                reset,
   nlbc_req_if.sink                            req_chan,
   nlbc_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [nlbc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nlbc_pkg::COEF_BITS-1:0]      csr_wr_data
);
   import nlbc_pkg::*;

   coef_set_type              coefs;
   mac_cmd_type               mac_cmd;
   sample_type                mac_result;
   frame_done_type            done;
   logic                      out_busy;
   logic                      rsp_valid_ff, rsp_valid_in;
   sample_type [CHANNELS-1:0] rsp_frame_ff, rsp_frame_in;

   nlbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .coefs       (coefs)
   );

   nlbc_mac u_mac (
      .clock  (clock),
      .cmd    (mac_cmd),
      .result (mac_result)
   );

   nlbc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .coefs      (coefs),
      .mac_cmd    (mac_cmd),
      .mac_result (mac_result),
      .out_busy   (out_busy),
      .done       (done)
   );

   // Output register: a finished frame is loaded only once the previous beat has gone.
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_frame_in = rsp_frame_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = done.frame;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.filtered_ch0 = rsp_frame_ff[0];
   assign rsp_chan.filtered_ch1 = rsp_frame_ff[1];
   assign rsp_chan.filtered_ch2 = rsp_frame_ff[2];
   assign rsp_chan.filtered_ch3 = rsp_frame_ff[3];

endmodule

/* sv/nlbc_checker.sv */
// Port-level checks of the biquad cascade and the bind that attaches them.
`include "notch_lowpass_biquad_cascade_defines.svh"

module nlbc_checker (
   input logic                                                      clock,
   input logic                                                      reset,
   input logic                                                      req_valid,
   input logic                                                      req_ready,
   input logic                                                      rsp_valid,
   input logic                                                      rsp_ready,
   input logic [nlbc_pkg::CHANNELS*nlbc_pkg::SAMPLE_BITS-1:0]       rsp_data
);

   // Reset leaves the block idle with no result pending.
   `NLBC_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, req_ready && !rsp_valid, "not idle after reset")

   // Once a frame is taken the block is busy filtering it.
   `NLBC_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

   // A new result only appears at the end of a busy period.
   `NLBC_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(!req_ready), "result from nowhere")

   // A stalled result beat keeps its data.
   `NLBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result beat changed while stalled")

endmodule

bind notch_lowpass_biquad_cascade nlbc_checker u_nlbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  ({rsp_chan.filtered_ch3, rsp_chan.filtered_ch2,
                rsp_chan.filtered_ch1, rsp_chan.filtered_ch0})
);

/* tb/notch_lowpass_biquad_cascade_tb.sv */
// Self-checking testbench for the four-channel notch then lowpass biquad cascade.
`timescale 1ns / 100ps

module notch_lowpass_biquad_cascade_tb;
   import nlbc_pkg::*;

   typedef sample_type [CHANNELS-1:0] frame_type;

   localparam int NUM_COEFS = int'(REG_LOWPASS_FB_TWO) + 1;
   // Indexes past the last coefficient register; the block must ignore writes to them.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_SIX   = CSR_INDEX_BITS'(6);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_SEVEN = CSR_INDEX_BITS'(7);

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam coef_type   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_type   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};

   localparam real SAMPLE_RATE_HZ = 1000.0;
   localparam real PI             = 3.14159265358979;
   localparam int  PHASE_FRAMES   = 308;
   localparam int  TAIL_CYCLES    = 60;
   localparam int  HOLD_CYCLES    = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [COEF_BITS-1:0]      csr_wr_data = '0;

   nlbc_req_if req ();
   nlbc_rsp_if rsp ();

   notch_lowpass_biquad_cascade dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Coefficients as the block should hold them, and the filter history per channel.
   // Index 0 of a history holds the latest value, index 1 the one before it.
   // The lowpass input history equals the notch output history, so one copy serves both.
   coef_type   coef_bank [NUM_COEFS]    = '{default: '0};
   sample_type raw_past [CHANNELS][2]   = '{default: '0};
   sample_type notch_past [CHANNELS][2] = '{default: '0};
   sample_type lp_out_past [CHANNELS][2] = '{default: '0};

   frame_type frames_to_send [$];
   frame_type expected_filtered [$];
   frame_type next_beat;
   frame_type wanted;
   frame_type got;

   int  outstanding = 0;
   int  failures    = 0;
   int  burst_left  = 0;
   int  gap_left    = 0;
   int  ready_left  = 0;
   bit  ready_level = 1'b1;
   bit  hold_off    = 1'b0;
   bit  hold_off_armed = 1'b0;

   // Clock: 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One direct-form-I stage: exact sum of five products, round half up, saturate.
   function automatic sample_type biquad(longint b0, longint b1, longint b2, longint a1,
                                         longint a2, sample_type x, sample_type x1,
                                         sample_type x2, sample_type y1, sample_type y2);
      longint acc;
      acc = b0 * x + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2;
      acc = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (acc > longint'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end
      if (acc < longint'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return sample_type'(acc);
   endfunction

   // Runs one raw frame through notch and lowpass, advancing the history.
   function automatic frame_type filter_frame(frame_type raw);
      frame_type  filtered;
      sample_type notched;
      longint     ng, nf1, nf2, lg, lf1, lf2;
      ng  = coef_bank[REG_NOTCH_GAIN];
      nf1 = coef_bank[REG_NOTCH_FB_ONE];
      nf2 = coef_bank[REG_NOTCH_FB_TWO];
      lg  = coef_bank[REG_LOWPASS_GAIN];
      lf1 = coef_bank[REG_LOWPASS_FB_ONE];
      lf2 = coef_bank[REG_LOWPASS_FB_TWO];
      for (int ch = 0; ch < CHANNELS; ch++) begin
         // The notch uses its a1 as b1 too; the lowpass b1 is twice its gain.
         notched = biquad(ng, nf1, ng, nf1, nf2, raw[ch], raw_past[ch][0], raw_past[ch][1],
                          notch_past[ch][0], notch_past[ch][1]);
         filtered[ch] = biquad(lg, 2 * lg, lg, lf1, lf2, notched, notch_past[ch][0],
                               notch_past[ch][1], lp_out_past[ch][0], lp_out_past[ch][1]);
         raw_past[ch][1]    = raw_past[ch][0];
         raw_past[ch][0]    = raw[ch];
         notch_past[ch][1]  = notch_past[ch][0];
         notch_past[ch][0]  = notched;
         lp_out_past[ch][1] = lp_out_past[ch][0];
         lp_out_past[ch][0] = filtered[ch];
      end
      return filtered;
   endfunction

   function automatic void check_field(int ch, sample_type want, sample_type seen);
      if (seen !== want) begin
         $error("filtered_ch%0d: expected %0d, actual %0d", ch, want, seen);
         failures++;
      end
   endfunction

   // Full-range noise, with extremes and quieter stretches mixed in.
   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3, 4: return sample_type'($urandom);
         default: return sample_type'(int'($urandom_range(0, 8000)) - 4000);
      endcase
   endfunction

   function automatic coef_type random_coef();
      case ($urandom_range(0, 5))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return '0;
         3: return coef_type'($urandom);
         default: return coef_type'(int'($urandom_range(0, 131072)) - 65536);
      endcase
   endfunction

   function automatic coef_type q_format(real value);
      return coef_type'($rtoi(value * (2.0 ** COEF_FRAC_BITS)));
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         f[ch] = random_sample();
      end
      return f;
   endfunction

   task automatic queue_frame(frame_type f);
      frames_to_send.insert(frames_to_send.size(), f);
      outstanding++;
   endtask

   // One register write; the model follows only for indexes that exist.
   task automatic write_coef(logic [CSR_INDEX_BITS-1:0] reg_index, coef_type value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= reg_index;
      csr_wr_data <= value;
      if (reg_index <= REG_LOWPASS_FB_TWO) begin
         coef_bank[reg_index] = value;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all_coefs(coef_type value);
      for (int i = 0; i < NUM_COEFS; i++) begin
         write_coef(CSR_INDEX_BITS'(i), value);
      end
   endtask

   // Coefficients of a real notch and a Butterworth lowpass, as software would load them.
   task automatic load_cookbook(real notch_hz, real notch_q, real cutoff_hz);
      real w, c, alpha, a0;
      w     = 2.0 * PI * notch_hz / SAMPLE_RATE_HZ;
      c     = $cos(w);
      alpha = $sin(w) / (2.0 * notch_q);
      a0    = 1.0 + alpha;
      write_coef(REG_NOTCH_GAIN, q_format(1.0 / a0));
      write_coef(REG_NOTCH_FB_ONE, q_format(-2.0 * c / a0));
      write_coef(REG_NOTCH_FB_TWO, q_format((1.0 - alpha) / a0));
      w     = 2.0 * PI * cutoff_hz / SAMPLE_RATE_HZ;
      c     = $cos(w);
      alpha = $sin(w) / (2.0 * 0.7071);
      a0    = 1.0 + alpha;
      write_coef(REG_LOWPASS_GAIN, q_format((1.0 - c) / 2.0 / a0));
      write_coef(REG_LOWPASS_FB_ONE, q_format(-2.0 * c / a0));
      write_coef(REG_LOWPASS_FB_TWO, q_format((1.0 - alpha) / a0));
   endtask

   // The block is idle once every queued frame has come back filtered.
   task automatic wait_idle();
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Sender: predicts each accepted beat and offers frames in bursts with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_filtered.insert(expected_filtered.size(),
                                     filter_frame({req.sample_ch3, req.sample_ch2,
                                                   req.sample_ch1, req.sample_ch0}));
         end
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (frames_to_send.size() > 0) begin
               next_beat = frames_to_send[0];
               frames_to_send.delete(0);
               req.sample_ch0 <= next_beat[0];
               req.sample_ch1 <= next_beat[1];
               req.sample_ch2 <= next_beat[2];
               req.sample_ch3 <= next_beat[3];
               req.valid      <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(1, 4);
                     default: gap_left = $urandom_range(5, 70);
                  endcase
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each filtered beat against the oldest prediction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_filtered.size() == 0) begin
               $error("filtered frame arrived with no frame outstanding");
               failures++;
            end else begin
               wanted = expected_filtered[0];
               expected_filtered.delete(0);
               got    = {rsp.filtered_ch3, rsp.filtered_ch2, rsp.filtered_ch1,
                         rsp.filtered_ch0};
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  check_field(ch, wanted[ch], got[ch]);
               end
               outstanding--;
            end
         end
         if (ready_left > 0) begin
            ready_left--;
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  ready_level = 1'b1;
                  ready_left  = $urandom_range(200, 400);
               end
               1, 2: begin
                  ready_level = 1'b0;
                  ready_left  = $urandom_range(1, 90);
               end
               default: begin
                  ready_level = 1'b1;
                  ready_left  = $urandom_range(1, 60);
               end
            endcase
         end
         rsp.ready <= ready_level && !hold_off;
      end
   end

   // One long receiver hold-off while frames keep coming, so the block backs up.
   initial begin
      wait (hold_off_armed);
      repeat (20) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Stimulus: directed frames over extreme settings, then random phases.
   initial begin
      req.valid      = 1'b0;
      req.sample_ch0 = '0;
      req.sample_ch1 = '0;
      req.sample_ch2 = '0;
      req.sample_ch3 = '0;
      rsp.ready      = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Coefficients clear on reset, so even extreme samples must come back as zero.
      queue_frame({CHANNELS{SAMPLE_MAX}});
      queue_frame({CHANNELS{SAMPLE_MIN}});
      queue_frame({SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX});
      queue_frame('0);
      queue_frame(random_frame());
      queue_frame(random_frame());
      wait_idle();

      // Every coefficient at its top value; the spare index write must not land.
      write_all_coefs(COEF_MAX);
      write_coef(REG_SPARE_SIX, COEF_MIN);
      for (int k = 0; k < 8; k++) begin
         queue_frame(k[0] ? {CHANNELS{SAMPLE_MIN}} : {CHANNELS{SAMPLE_MAX}});
      end
      wait_idle();

      // Every coefficient at its bottom value, driven by a step and then silence.
      write_all_coefs(COEF_MIN);
      write_coef(REG_SPARE_SEVEN, COEF_MAX);
      for (int k = 0; k < 8; k++) begin
         queue_frame((k < 4) ? {CHANNELS{SAMPLE_MAX}} : frame_type'('0));
      end
      wait_idle();

      // Random phases, each under a fresh coefficient set.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0, 2: load_cookbook(real'($urandom_range(20, 200)),
                                real'($urandom_range(5, 100)) / 10.0,
                                real'($urandom_range(10, 400)));
            4: write_all_coefs(COEF_MAX);
            default: begin
               for (int i = 0; i < NUM_COEFS; i++) begin
                  write_coef(CSR_INDEX_BITS'(i), random_coef());
               end
            end
         endcase
         if ($urandom_range(0, 1)) begin
            write_coef($urandom_range(0, 1) ? REG_SPARE_SIX : REG_SPARE_SEVEN,
                       coef_type'($urandom));
         end
         for (int k = 0; k < PHASE_FRAMES; k++) begin
            queue_frame(random_frame());
         end
         if (phase == 2) begin
            hold_off_armed = 1'b1;
         end
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && expected_filtered.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog, set well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/nlbc_pkg.sv
sv/nlbc_if.sv
sv/nlbc_csr.sv
sv/nlbc_mac.sv
sv/nlbc_seq.sv
sv/notch_lowpass_biquad_cascade.sv
sv/nlbc_checker.sv
tb/notch_lowpass_biquad_cascade_tb.sv
